FILE: hdl/wcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcp_pkg
// shared types and constants of the wav chunk parser
// ----------------------------------------------------------------------------
package wcp_pkg;

  // parse phase codes
  localparam logic [2:0] PH_RIFF  = 3'd0;
  localparam logic [2:0] PH_HDR   = 3'd1;
  localparam logic [2:0] PH_FMT   = 3'd2;
  localparam logic [2:0] PH_SKIP  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_AFTER = 3'd5;
  localparam logic [2:0] PH_HALT  = 3'd6;

  // chunk tags as they read little-endian
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SHORT       = 3'd1;
  localparam logic [2:0] ST_BAD_FMT     = 3'd2;
  localparam logic [2:0] ST_MISSING     = 3'd3;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;
  localparam logic [2:0] ST_BAD_SIZE    = 3'd5;
  localparam logic [2:0] ST_EMPTY       = 3'd6;

  // item kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // header geometry
  localparam int unsigned RiffTagPos  = 3;
  localparam int unsigned WaveTagPos  = 11;
  localparam int unsigned MinFileLast = 43;
  localparam int unsigned FmtBytes    = 16;
  localparam int unsigned HdrBytes    = 8;

  localparam int unsigned TdataBits = 64;

  // one result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload;
    logic [2:0]  status;
    logic [15:0] channels;
    logic [31:0] rate;
    logic        last;
  } wcp_item_t;

  // up to two results pushed per accepted byte
  typedef struct packed {
    logic [1:0] count;
    wcp_item_t  first;
    wcp_item_t  second;
  } wcp_push_t;

endpackage

FILE: hdl/wcp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcp_parser
// per-byte riff/wave chunk walker, yields payload and status items
// ----------------------------------------------------------------------------
module wcp_parser import wcp_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       final_i,
  output wcp_push_t  push_o
);

  logic [2:0]            phase_q, phase_d;
  logic [COUNT_BITS-1:0] pos_q, pos_d;
  logic [63:0]           hs_q, hs_d;
  logic [32:0]           rem_q, rem_d;
  logic [4:0]            fbi_q, fbi_d;
  logic [15:0]           fmt_q, fmt_d;
  logic [15:0]           chan_q, chan_d;
  logic [31:0]           rate_q, rate_d;
  logic [15:0]           bits_q, bits_d;
  logic [2:0]            err_q, err_d;

  // next state and results for one byte
  always_comb begin
    logic [4:0]  fbi_inc;
    logic [31:0] tag;
    logic [31:0] size;
    logic [32:0] padded;
    logic [32:0] rem_dec;
    logic [2:0]  st;
    wcp_item_t   pay_item;
    wcp_item_t   st_item;
    logic        emit;

    phase_d = phase_q;
    pos_d   = pos_q;
    hs_d    = hs_q;
    rem_d   = rem_q;
    fbi_d   = fbi_q;
    fmt_d   = fmt_q;
    chan_d  = chan_q;
    rate_d  = rate_q;
    bits_d  = bits_q;
    err_d   = err_q;
    emit    = 1'b0;
    st      = ST_MISSING;

    fbi_inc = fbi_q + 5'd1;
    hs_d    = {byte_i, hs_q[63:8]};
    tag     = hs_d[31:0];
    size    = hs_d[63:32];
    padded  = ({1'b0, size} + 33'd1) & ~33'd1;
    rem_dec = (rem_q != '0) ? rem_q - 33'd1 : rem_q;

    unique case (phase_q)
      PH_RIFF: begin
        if (pos_q == COUNT_BITS'(RiffTagPos) && size != TAG_RIFF) begin
          err_d   = ST_SHORT;
          phase_d = PH_HALT;
        end else if (pos_q == COUNT_BITS'(WaveTagPos)) begin
          if (size != TAG_WAVE) begin
            err_d   = ST_SHORT;
            phase_d = PH_HALT;
          end else begin
            phase_d = PH_HDR;
            fbi_d   = '0;
          end
        end
      end
      PH_HDR: begin
        fbi_d = fbi_inc;
        if (fbi_inc >= 5'(HdrBytes)) begin
          fbi_d = '0;
          // chunk header complete
          if (tag == TAG_FMT) begin
            if (size < 32'(FmtBytes)) begin
              err_d   = ST_BAD_FMT;
              phase_d = PH_HALT;
            end else begin
              rem_d   = padded - 33'(FmtBytes);
              phase_d = PH_FMT;
            end
          end else if (tag == TAG_DATA) begin
            if (fmt_q == 16'd0) begin
              err_d   = ST_MISSING;
              phase_d = PH_HALT;
            end else if (fmt_q != 16'd1 || bits_q != 16'd16 ||
                         (chan_q != 16'd1 && chan_q != 16'd2)) begin
              err_d   = ST_UNSUPPORTED;
              phase_d = PH_HALT;
            end else if (rate_q == 32'd0) begin
              err_d   = ST_BAD_SIZE;
              phase_d = PH_HALT;
            end else if (size == 32'd0) begin
              err_d   = ST_EMPTY;
              phase_d = PH_AFTER;
            end else begin
              rem_d   = {1'b0, size};
              phase_d = PH_DATA;
            end
          end else begin
            rem_d   = padded;
            phase_d = (padded == '0) ? PH_HDR : PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        // fields land as their bytes arrive
        unique case (fbi_q[3:0])
          4'd0:    fmt_d[7:0]    = byte_i;
          4'd1:    fmt_d[15:8]   = byte_i;
          4'd2:    chan_d[7:0]   = byte_i;
          4'd3:    chan_d[15:8]  = byte_i;
          4'd4:    rate_d[7:0]   = byte_i;
          4'd5:    rate_d[15:8]  = byte_i;
          4'd6:    rate_d[23:16] = byte_i;
          4'd7:    rate_d[31:24] = byte_i;
          4'd14:   bits_d[7:0]   = byte_i;
          4'd15:   bits_d[15:8]  = byte_i;
          default: ;
        endcase
        fbi_d = fbi_inc;
        if (fbi_inc >= 5'(FmtBytes)) begin
          fbi_d   = '0;
          phase_d = (rem_q == '0) ? PH_HDR : PH_SKIP;
        end
      end
      PH_SKIP: begin
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          phase_d = PH_HDR;
          fbi_d   = '0;
        end
      end
      PH_DATA: begin
        emit  = 1'b1;
        rem_d = rem_dec;
        if (rem_dec == '0) phase_d = PH_AFTER;
      end
      default: ;
    endcase

    // saturating byte position
    if (pos_q != '1) pos_d = pos_q + COUNT_BITS'(1);

    // final status, short file first
    priority if (pos_q < COUNT_BITS'(MinFileLast)) st = ST_SHORT;
    else if (err_d != ST_OK)                          st = err_d;
    else if (phase_d == PH_DATA)                      st = ST_BAD_SIZE;
    else if (phase_d == PH_AFTER)                     st = ST_OK;
    else if (phase_d == PH_FMT)                       st = ST_BAD_FMT;
    else                                              st = ST_MISSING;

    pay_item          = '0;
    pay_item.kind     = KIND_PAYLOAD;
    pay_item.payload  = byte_i;

    st_item          = '0;
    st_item.kind     = KIND_STATUS;
    st_item.status   = st;
    st_item.channels = chan_d;
    st_item.rate     = rate_d;
    st_item.last     = 1'b1;

    push_o = '0;
    if (accept_i) begin
      if (emit) begin
        push_o.first  = pay_item;
        push_o.second = st_item;
        push_o.count  = final_i ? 2'd2 : 2'd1;
      end else if (final_i) begin
        push_o.first = st_item;
        push_o.count = 2'd1;
      end
    end

    // last byte returns the parser to its reset state
    if (final_i) begin
      phase_d = PH_RIFF;
      pos_d   = '0;
      hs_d    = '0;
      rem_d   = '0;
      fbi_d   = '0;
      fmt_d   = '0;
      chan_d  = '0;
      rate_d  = '0;
      bits_d  = '0;
      err_d   = ST_OK;
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      pos_q   <= '0;
      hs_q    <= '0;
      rem_q   <= '0;
      fbi_q   <= '0;
      fmt_q   <= '0;
      chan_q  <= '0;
      rate_q  <= '0;
      bits_q  <= '0;
      err_q   <= ST_OK;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      hs_q    <= hs_d;
      rem_q   <= rem_d;
      fbi_q   <= fbi_d;
      fmt_q   <= fmt_d;
      chan_q  <= chan_d;
      rate_q  <= rate_d;
      bits_q  <= bits_d;
      err_q   <= err_d;
    end
  end

endmodule

FILE: hdl/wcp_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcp_out_queue
// four-entry result queue taking up to two items per cycle
// ----------------------------------------------------------------------------
module wcp_out_queue import wcp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  wcp_push_t push_i,
  output logic      room_o,
  output logic      valid_o,
  input  logic      ready_i,
  output wcp_item_t item_o
);

  wcp_item_t  mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 3'd0);
  assign item_o  = mem_q[rd_q];
  // room for two more items
  assign room_o  = (cnt_q <= 3'd2);

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q] <= push_i.first;
    if (push_i.count == 2'd2) mem_q[wr_q + 2'd1] <= push_i.second;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_i.count;
      rd_q  <= rd_q + 2'(pop);
      cnt_q <= cnt_q + 3'(push_i.count) - 3'(pop);
    end
  end

endmodule

FILE: hdl/wav_chunk_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_chunk_parser
// streams a wav file byte by byte, passes data chunk payload, reports status
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one file byte per request in tdata; tlast marks the last
//    byte of the file. The next byte after it starts a new file.
//  - m_axis carries result items. tuser is the item kind (0 payload byte,
//    1 status); tlast is set on the status item, which closes each file.
//  - one byte is accepted every cycle while the output keeps up. A payload
//    byte is registered in the result queue before it shows on m_axis; the
//    last byte of a file may push a payload item and a status item at once.
//  - results go through a four-entry queue; s_axis_tready drops when fewer
//    than two entries are free, so a stalled receiver backs up the input
//    and nothing is lost.
//  - reset clears the parser to the start of a file and empties the queue.
//  - status is final for the file: payload already sent before an error is
//    not withdrawn, the receiver drops it when the status is nonzero.
// ----------------------------------------------------------------------------
module wav_chunk_parser import wcp_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // in_byte[7:0]
  input  logic                 s_axis_tlast,  // is_final_byte
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // payload_byte[7:0], status_code[10:8], channel_count[26:11],
  // sample_rate_hz[58:27], zero fill above
  output logic [TdataBits-1:0] m_axis_tdata,
  output logic                 m_axis_tuser,  // item_kind
  output logic                 m_axis_tlast   // last_result
);

  logic      accept;
  logic      room;
  wcp_push_t push;
  wcp_item_t item;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  // chunk walker
  wcp_parser #(
    .COUNT_BITS(COUNT_BITS)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (s_axis_tdata),
    .final_i (s_axis_tlast),
    .push_o  (push)
  );

  // result queue
  wcp_out_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .item_o (item)
  );

  // output packing
  assign m_axis_tdata = {5'd0, item.rate, item.channels, item.status, item.payload};
  assign m_axis_tuser = item.kind;
  assign m_axis_tlast = item.last;

endmodule
